[hw/rtl/c2u_pkg.sv]
`timescale 1ns / 1ps

package c2u_pkg;

  localparam logic [2:0] MODE_PASS   = 3'd0;
  localparam logic [2:0] MODE_ASCII  = 3'd1;
  localparam logic [2:0] MODE_LATIN1 = 3'd2;
  localparam logic [2:0] MODE_U16LE  = 3'd3;
  localparam logic [2:0] MODE_U16BE  = 3'd4;
  localparam logic [2:0] MODE_U16BOM = 3'd5;

  localparam logic [15:0] CP_REPL   = 16'hfffd;
  localparam logic [20:0] CP_SUPP   = 21'h10000;
  localparam int          QUEUE_DEPTH = 2;
  localparam int          QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int          QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_text;
  } out_item_t;

  // One decoded input item: one or two code points, or one raw byte.
  typedef struct packed {
    logic [20:0] cp0;
    logic [15:0] cp1;
    logic        two_cp;
    logic        raw;
    logic        eob;
  } job_t;

  function automatic logic [1:0] utf8_len_m1(input logic [20:0] cp);
    logic [1:0] n;
    if (cp <= 21'h7f) begin
      n = 2'd0;
    end else if (cp <= 21'h7ff) begin
      n = 2'd1;
    end else if (cp <= 21'hffff) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
    logic [1:0] n;
    logic [7:0] b;
    n = utf8_len_m1(cp);
    case ({n, idx})
      4'b0000: b = cp[7:0];
      4'b0100: b = {3'b110, cp[10:6]};
      4'b0101: b = {2'b10, cp[5:0]};
      4'b1000: b = {4'b1110, cp[15:12]};
      4'b1001: b = {2'b10, cp[11:6]};
      4'b1010: b = {2'b10, cp[5:0]};
      4'b1100: b = {5'b11110, cp[20:18]};
      4'b1101: b = {2'b10, cp[17:12]};
      4'b1110: b = {2'b10, cp[11:6]};
      4'b1111: b = {2'b10, cp[5:0]};
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[hw/rtl/c2u_front.sv]
`timescale 1ns / 1ps

module c2u_front import c2u_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t in_data,
  input  logic     cfg_we,
  input  logic [2:0] cfg_data,
  output logic     enq,
  output job_t     job
);

  logic [2:0] mode_r;
  logic [7:0] held_r, held_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic [9:0] hsb_r, hsb_nxt;
  logic       pend_r, pend_nxt;
  logic       at_start_r, at_start_nxt;
  logic       le_r, le_nxt;

  logic [7:0]  b;
  logic        eob;
  logic        utf16;
  logic        bom;
  logic        le_eff;
  logic [15:0] u;
  logic        is_high, is_low;
  logic [20:0] comb_cp;
  logic        emit;

  assign b     = in_data.data_byte;
  assign eob   = in_data.end_of_buffer;
  assign utf16 = mode_r inside {MODE_U16LE, MODE_U16BE, MODE_U16BOM};
  assign bom   = at_start_r && (mode_r == MODE_U16BOM) &&
                 ((held_r == 8'hff && b == 8'hfe) || (held_r == 8'hfe && b == 8'hff));
  assign le_eff  = le_r;
  assign u       = le_eff ? {b, held_r} : {held_r, b};
  assign is_high = u inside {[16'hd800:16'hdbff]};
  assign is_low  = u inside {[16'hdc00:16'hdfff]};
  assign comb_cp = CP_SUPP + {1'b0, hsb_r, u[9:0]};

  always_comb begin
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    hsb_nxt        = hsb_r;
    pend_nxt       = pend_r;
    at_start_nxt   = at_start_r;
    le_nxt         = le_r;
    emit           = 1'b0;
    job            = '0;
    job.eob        = eob;
    job.cp0        = {5'b0, CP_REPL};
    job.cp1        = CP_REPL;
    if (utf16) begin
      if (!held_valid_r) begin
        if (at_start_r) begin
          le_nxt = (mode_r == MODE_U16LE);
        end
        held_nxt       = b;
        held_valid_nxt = 1'b1;
        if (eob) begin
          emit       = 1'b1;
          job.two_cp = pend_r;
        end
      end else begin
        held_valid_nxt = 1'b0;
        at_start_nxt   = 1'b0;
        if (bom) begin
          le_nxt = (held_r == 8'hff);
        end else if (pend_r) begin
          pend_nxt = 1'b0;
          hsb_nxt  = '0;
          emit     = 1'b1;
          if (is_low) begin
            job.cp0 = comb_cp;
          end else if (is_high) begin
            hsb_nxt    = u[9:0];
            pend_nxt   = 1'b1;
            job.two_cp = eob;
          end else begin
            job.two_cp = 1'b1;
            if (!is_low) begin
              job.cp1 = u;
            end
          end
        end else begin
          if (is_high) begin
            hsb_nxt  = u[9:0];
            pend_nxt = 1'b1;
            emit     = eob;
          end else begin
            emit = 1'b1;
            if (!is_low) begin
              job.cp0 = {5'b0, u};
            end
          end
        end
      end
    end else begin
      at_start_nxt = 1'b0;
      emit         = 1'b1;
      case (mode_r)
        MODE_ASCII: begin
          if (b <= 8'h7f) begin
            job.cp0 = {13'b0, b};
          end
        end
        MODE_LATIN1: begin
          job.cp0 = {13'b0, b};
        end
        default: begin
          job.raw = 1'b1;
          job.cp0 = {13'b0, b};
        end
      endcase
    end
    if (eob) begin
      held_nxt       = '0;
      held_valid_nxt = 1'b0;
      hsb_nxt        = '0;
      pend_nxt       = 1'b0;
      at_start_nxt   = 1'b1;
      le_nxt         = 1'b0;
    end
  end

  assign enq = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_PASS;
      held_r       <= '0;
      held_valid_r <= 1'b0;
      hsb_r        <= '0;
      pend_r       <= 1'b0;
      at_start_r   <= 1'b1;
      le_r         <= 1'b0;
    end else if (cfg_we) begin
      mode_r       <= cfg_data;
      held_r       <= '0;
      held_valid_r <= 1'b0;
      hsb_r        <= '0;
      pend_r       <= 1'b0;
      at_start_r   <= 1'b1;
      le_r         <= 1'b0;
    end else if (accept) begin
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
      hsb_r        <= hsb_nxt;
      pend_r       <= pend_nxt;
      at_start_r   <= at_start_nxt;
      le_r         <= le_nxt;
    end
  end

endmodule

[hw/rtl/c2u_queue.sv]
`timescale 1ns / 1ps

module c2u_queue import c2u_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  job_t wr_job,
  input  logic rd_en,
  output job_t rd_job,
  output logic q_valid,
  output logic q_full
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign q_valid = (cnt_r != '0);
  assign q_full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign rd_job  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

[hw/rtl/c2u_back.sv]
`timescale 1ns / 1ps

module c2u_back import c2u_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  job_t      q_job,
  output logic      q_pop,
  input  logic      out_pop,
  output logic      out_valid,
  output out_item_t out_item
);

  job_t        job_r;
  logic        job_valid_r;
  logic        sel_r;
  logic [1:0]  idx_r;
  logic        out_valid_r;
  out_item_t   out_item_r;

  logic        emit;
  logic [20:0] cur_cp;
  logic [1:0]  len_m1;
  logic        cp_done;
  logic        job_done;
  logic        load;
  logic [7:0]  byte_val;

  assign emit     = job_valid_r && (!out_valid_r || out_pop);
  assign cur_cp   = sel_r ? {5'b0, job_r.cp1} : job_r.cp0;
  assign len_m1   = job_r.raw ? 2'd0 : utf8_len_m1(cur_cp);
  assign cp_done  = (idx_r == len_m1);
  assign job_done = cp_done && (sel_r || !job_r.two_cp);
  assign load     = q_valid && (!job_valid_r || (emit && job_done));
  assign q_pop    = load;
  assign byte_val = job_r.raw ? job_r.cp0[7:0] : utf8_byte(cur_cp, idx_r);

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= q_job;
    end
    if (emit) begin
      out_item_r.out_byte    <= byte_val;
      out_item_r.last_of_run <= job_done;
      out_item_r.end_of_text <= job_done && job_r.eob;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      sel_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        job_valid_r <= 1'b1;
        sel_r       <= 1'b0;
        idx_r       <= '0;
      end else if (emit && job_done) begin
        job_valid_r <= 1'b0;
      end else if (emit) begin
        if (cp_done) begin
          sel_r <= 1'b1;
          idx_r <= '0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/charset_to_utf8_transcoder.sv]
`timescale 1ns / 1ps
// Channel   Handshake               Payload
// input     push / full             in_data  (in_item_t)
// result    empty / pop             out_data (out_item_t)
// config    cfg_valid / cfg_ready   cfg_data (3-bit mode)
//
// One input item is taken per cycle while the two-entry job queue has room.
// The expander emits one UTF-8 byte per cycle while the result side does not stall,
// and an item produces 1 to 6 bytes; items producing no byte never reach it.
// Reset is synchronous, active low; cfg_ready is always high.
// Result stalls back up through the queue to full.
module charset_to_utf8_transcoder import c2u_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  in_item_t   in_data,
  output logic       empty,
  input  logic       pop,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_data
);

  logic accept;
  logic enq;
  job_t fr_job;
  job_t q_job;
  logic q_valid;
  logic q_full;
  logic q_pop;
  logic out_valid;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;
  assign empty     = !out_valid;

  c2u_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .enq      (enq),
    .job      (fr_job)
  );

  c2u_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (enq),
    .wr_job  (fr_job),
    .rd_en   (q_pop),
    .rd_job  (q_job),
    .q_valid (q_valid),
    .q_full  (q_full)
  );

  c2u_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .out_pop   (pop && !empty),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

endmodule
